// ===== hw/rtl/fvn_pkg.sv =====
// ----------------------------------------------------------------------------
// fvn_pkg
// Shared constants, types and tables for the fractal value noise block.
// ----------------------------------------------------------------------------
package fvn_pkg;

   localparam int MAX_OCTAVES = 8;
   localparam int FRAC_BITS   = 16;
   localparam int OCT_W       = (MAX_OCTAVES > 1) ? $clog2(MAX_OCTAVES) : 1;

   localparam logic [31:0] MIX_MUL_A  = 32'h7feb352d;
   localparam logic [31:0] MIX_MUL_B  = 32'h846ca68b;
   localparam logic [31:0] SEED_MUL   = 32'h9e3779b1;
   localparam logic [31:0] SEED_STEP  = 32'd1013;
   localparam logic [31:0] AXIS_MUL [3] = '{32'd73856093, 32'd19349663, 32'd83492791};

   // w is a Q0.16 weight, kept one bit wider
   localparam int W_W = 17;

   // accumulator and normalisation
   localparam int ACC_W   = 32 + MAX_OCTAVES;
   localparam int LO_W    = ACC_W / 2;
   localparam int HI_W    = ACC_W - LO_W;
   localparam int RECIP_W = 24;
   localparam int PROD_W  = ACC_W + RECIP_W + 2;

   // round(2^(22+n) / (2^n - 1)), indexed by n-1
   localparam logic [RECIP_W-1:0] RECIP_TBL [8] = '{
      24'd8388608, 24'd5592405, 24'd4793490, 24'd4473924,
      24'd4329604, 24'd4260880, 24'd4227330, 24'd4210752
   };

   typedef struct packed {
      logic             vld;
      logic [OCT_W-1:0] octave;
      logic             last;
   } sb_type;

endpackage

// ===== hw/rtl/fvn_mix_cell.sv =====
// ----------------------------------------------------------------------------
// fvn_mix_cell
// One xorshift-multiply hash round over two registered steps.
// ----------------------------------------------------------------------------
module fvn_mix_cell (
   input  logic        clock,
   input  logic [31:0] h_in,
   input  logic [31:0] p_in,
   output logic [31:0] h_out
);

   logic [31:0] x0;
   logic [31:0] a_in, a_ff;
   logic [31:0] b_in, b_ff;

   assign x0    = h_in ^ p_in;
   assign a_in  = (x0 ^ (x0 >> 16)) * fvn_pkg::MIX_MUL_A;
   assign b_in  = (a_ff ^ (a_ff >> 15)) * fvn_pkg::MIX_MUL_B;
   assign h_out = b_ff ^ (b_ff >> 16);

   always_ff @(posedge clock) begin
      a_ff <= a_in;
      b_ff <= b_in;
   end

endmodule

// ===== hw/rtl/fvn_fade.sv =====
// ----------------------------------------------------------------------------
// fvn_fade
// Smootherstep weight of a Q0.16 fraction, three registered steps.
// ----------------------------------------------------------------------------
module fvn_fade (
   input  logic                      clock,
   input  logic [15:0]               t,
   output logic [fvn_pkg::W_W-1:0]   w
);

   logic [31:0] tt_in, tt_ff;
   logic [15:0] t_ff;
   logic [15:0] t2;
   logic [31:0] t3r_in, t3r_ff;
   logic [37:0] p_sum;
   logic [21:0] p_in, p_ff;
   logic [15:0] t3;
   logic [37:0] wp;
   logic [fvn_pkg::W_W-1:0] w_in, w_ff;

   assign tt_in  = 32'(t) * 32'(t);
   assign t2     = tt_ff[31:16];
   assign t3r_in = 32'(t2) * 32'(t_ff);
   assign p_sum  = 38'd6 * 38'(tt_ff) + (38'd10 << 32) - 38'd15 * (38'(t_ff) << 16);
   assign p_in   = p_sum[37:16];
   assign t3     = t3r_ff[31:16];
   assign wp     = 38'(t3) * 38'(p_ff);
   assign w_in   = wp[16 +: fvn_pkg::W_W];
   assign w      = w_ff;

   always_ff @(posedge clock) begin
      tt_ff  <= tt_in;
      t_ff   <= t;
      t3r_ff <= t3r_in;
      p_ff   <= p_in;
      w_ff   <= w_in;
   end

endmodule

// ===== hw/rtl/fvn_lerp.sv =====
// ----------------------------------------------------------------------------
// fvn_lerp
// Registered linear blend a + ((b - a) * w) >>> 16.
// ----------------------------------------------------------------------------
module fvn_lerp (
   input  logic                    clock,
   input  logic signed [31:0]      a,
   input  logic signed [31:0]      b,
   input  logic [fvn_pkg::W_W-1:0] w,
   output logic signed [31:0]      r
);

   logic signed [32:0] diff;
   logic signed [50:0] prod;
   logic signed [50:0] sum;
   logic signed [31:0] r_in, r_ff;

   assign diff = 33'(b) - 33'(a);
   assign prod = 51'(diff) * 51'($signed({1'b0, w}));
   assign sum  = 51'(a) + (prod >>> 16);
   assign r_in = sum[31:0];
   assign r    = r_ff;

   always_ff @(posedge clock) begin
      r_ff <= r_in;
   end

endmodule

// ===== hw/rtl/fbm_value_noise_3d.sv =====
// ----------------------------------------------------------------------------
// fbm_value_noise_3d
// Fractal value noise over a 3D point: octaves are issued one per cycle into
// a chain of hash cells (eight corner lanes, three axis rounds each), then
// trilinear blending, accumulation and normalisation.
// ----------------------------------------------------------------------------
// Result: rsp_valid rises once the last of n octaves has left the octave
//         pipe, acc_done_ff and nrm_vld_ff; n = clamped octave count (1..8).
// Issue: one transaction at a time; busy is high until its result is out.
// Results are not back-pressured.
// Reset: synchronous; clears sequencer, pipe valids and the result strobe.
// ----------------------------------------------------------------------------
module fbm_value_noise_3d (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_coord_x,
   input  logic signed [31:0] req_coord_y,
   input  logic signed [31:0] req_coord_z,
   input  logic [31:0]        req_noise_seed,
   input  logic [3:0]         req_octave_count,
   output logic               rsp_valid,
   output logic signed [15:0] rsp_noise_value
);

   localparam int F     = fvn_pkg::FRAC_BITS;
   localparam int OCT_W = fvn_pkg::OCT_W;
   localparam int W_W   = fvn_pkg::W_W;
   localparam int ACC_W = fvn_pkg::ACC_W;
   localparam int LO_W  = fvn_pkg::LO_W;
   localparam int HI_W  = fvn_pkg::HI_W;
   localparam int RC_W  = fvn_pkg::RECIP_W;
   localparam int P_W   = fvn_pkg::PROD_W;

   localparam logic signed [P_W-1:0] RND    = P_W'(1) <<< (fvn_pkg::MAX_OCTAVES + 37);
   localparam logic signed [P_W-1:0] SAT_HI = P_W'(32767);
   localparam logic signed [P_W-1:0] SAT_LO = -P_W'(32768);

   typedef enum logic [1:0] {IDLE, ISSUE, DRAIN} state_type;

   state_type         state_ff;
   logic              busy_ff;
   logic [31:0]       coord_ff [3];
   logic [31:0]       seed_ff;
   logic [OCT_W-1:0]  nm1_ff;
   logic [OCT_W-1:0]  nm1_in;
   logic [OCT_W-1:0]  k_ff;
   logic              rsp_valid_ff;
   logic signed [15:0] rsp_value_ff, rsp_value_in;

   // issue stage
   logic [63:0]       c_sh   [3];
   logic [F+15:0]     fr_w   [3];
   logic [31:0]       ix_in  [3];
   logic [15:0]       t_in   [3];
   logic [31:0]       s_in;
   logic [31:0]       ix_ff  [3];
   logic [15:0]       t_ff   [3];
   logic [31:0]       s_ff;

   // hash operands
   logic [31:0]       h0_ff;
   logic [31:0]       pm_ff     [3][2];
   logic [31:0]       pmy_d_ff  [2][2];
   logic [31:0]       pmz_d_ff  [4][2];
   logic [31:0]       hx [8];
   logic [31:0]       hy [8];
   logic [31:0]       hz [8];
   logic signed [31:0] cv [8];

   // weights
   logic [W_W-1:0]    w_out [3];
   logic [W_W-1:0]    wd_ff [6][3];

   // blend
   logic signed [31:0] lx [4];
   logic signed [31:0] ly [2];
   logic signed [31:0] nv;

   fvn_pkg::sb_type   sb_ff [11];
   fvn_pkg::sb_type   sb_in;
   logic [10:0]       sb_vld;

   // accumulate and normalise
   logic signed [ACC_W-1:0] acc_ff, acc_in, acc_add;
   logic [OCT_W-1:0]        shamt;
   logic                    acc_done_ff;
   logic [LO_W+RC_W-1:0]    lo_ff;
   logic signed [HI_W+RC_W:0] hi_ff;
   logic                    nrm_vld_ff;
   logic [RC_W-1:0]         recip;
   logic signed [P_W-1:0]   sum_w, res_w;

   // ---------------------------------------------------------------- control
   always_comb begin
      if (req_octave_count == 4'd0) begin
         nm1_in = '0;
      end else if (32'(req_octave_count) > fvn_pkg::MAX_OCTAVES) begin
         nm1_in = OCT_W'(fvn_pkg::MAX_OCTAVES - 1);
      end else begin
         nm1_in = OCT_W'(req_octave_count - 4'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= IDLE;
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= nrm_vld_ff;
         unique case (state_ff)
            IDLE: begin
               if (start) begin
                  state_ff <= ISSUE;
                  busy_ff  <= 1'b1;
               end
            end
            ISSUE: begin
               if (k_ff == nm1_ff) begin
                  state_ff <= DRAIN;
               end
            end
            DRAIN: begin
               if (nrm_vld_ff) begin
                  state_ff <= IDLE;
                  busy_ff  <= 1'b0;
               end
            end
            default: begin
               state_ff <= IDLE;
               busy_ff  <= 1'b0;
            end
         endcase
      end
      rsp_value_ff <= rsp_value_in;
      if (state_ff == IDLE) begin
         coord_ff[0] <= req_coord_x;
         coord_ff[1] <= req_coord_y;
         coord_ff[2] <= req_coord_z;
         seed_ff     <= req_noise_seed;
         nm1_ff      <= nm1_in;
         k_ff        <= '0;
      end else begin
         k_ff <= k_ff + OCT_W'(1);
      end
   end

   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_noise_value = rsp_value_ff;

   // ---------------------------------------------------------------- issue
   always_comb begin
      for (int a = 0; a < 3; a++) begin
         c_sh[a]  = {{32{coord_ff[a][31]}}, coord_ff[a]} << k_ff;
         ix_in[a] = c_sh[a][F+31:F];
         fr_w[a]  = {c_sh[a][F-1:0], 16'b0};
         t_in[a]  = fr_w[a][F+15:F];
      end
      s_in  = seed_ff + 32'(k_ff) * fvn_pkg::SEED_STEP;
      sb_in = '{vld: (state_ff == ISSUE), octave: k_ff, last: (k_ff == nm1_ff)};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < 11; i++) begin
            sb_ff[i].vld <= 1'b0;
         end
      end else begin
         sb_ff[0].vld <= sb_in.vld;
         for (int i = 1; i < 11; i++) begin
            sb_ff[i].vld <= sb_ff[i-1].vld;
         end
      end
      sb_ff[0].octave <= sb_in.octave;
      sb_ff[0].last   <= sb_in.last;
      for (int i = 1; i < 11; i++) begin
         sb_ff[i].octave <= sb_ff[i-1].octave;
         sb_ff[i].last   <= sb_ff[i-1].last;
      end
      // lattice and hash operands
      ix_ff <= ix_in;
      t_ff  <= t_in;
      s_ff  <= s_in;
      h0_ff <= s_ff * fvn_pkg::SEED_MUL;
      for (int a = 0; a < 3; a++) begin
         pm_ff[a][0] <= ix_ff[a] * fvn_pkg::AXIS_MUL[a];
         pm_ff[a][1] <= (ix_ff[a] + 32'd1) * fvn_pkg::AXIS_MUL[a];
      end
      pmy_d_ff[0] <= pm_ff[1];
      pmy_d_ff[1] <= pmy_d_ff[0];
      pmz_d_ff[0] <= pm_ff[2];
      for (int i = 1; i < 4; i++) begin
         pmz_d_ff[i] <= pmz_d_ff[i-1];
      end
      wd_ff[0] <= w_out;
      for (int i = 1; i < 6; i++) begin
         wd_ff[i] <= wd_ff[i-1];
      end
   end

   // ---------------------------------------------------------------- cells
   for (genvar a = 0; a < 3; a++) begin : g_fade
      fvn_fade u_fade (
         .clock (clock),
         .t     (t_ff[a]),
         .w     (w_out[a])
      );
   end

   for (genvar c = 0; c < 8; c++) begin : g_lane
      fvn_mix_cell u_mix_x (
         .clock (clock),
         .h_in  (h0_ff),
         .p_in  (pm_ff[0][c % 2]),
         .h_out (hx[c])
      );
      fvn_mix_cell u_mix_y (
         .clock (clock),
         .h_in  (hx[c]),
         .p_in  (pmy_d_ff[1][(c / 2) % 2]),
         .h_out (hy[c])
      );
      fvn_mix_cell u_mix_z (
         .clock (clock),
         .h_in  (hy[c]),
         .p_in  (pmz_d_ff[3][c / 4]),
         .h_out (hz[c])
      );
      assign cv[c] = $signed({~hz[c][31], hz[c][30:0]});
   end

   for (genvar j = 0; j < 4; j++) begin : g_lerp_x
      fvn_lerp u_lerp (
         .clock (clock),
         .a     (cv[2*j]),
         .b     (cv[2*j+1]),
         .w     (wd_ff[3][0]),
         .r     (lx[j])
      );
   end

   for (genvar j = 0; j < 2; j++) begin : g_lerp_y
      fvn_lerp u_lerp (
         .clock (clock),
         .a     (lx[2*j]),
         .b     (lx[2*j+1]),
         .w     (wd_ff[4][1]),
         .r     (ly[j])
      );
   end

   fvn_lerp u_lerp_z (
      .clock (clock),
      .a     (ly[0]),
      .b     (ly[1]),
      .w     (wd_ff[5][2]),
      .r     (nv)
   );

   // ---------------------------------------------------------------- sum
   always_comb begin
      shamt   = OCT_W'(fvn_pkg::MAX_OCTAVES - 1) - sb_ff[10].octave;
      acc_add = ACC_W'(nv) <<< shamt;
      acc_in  = (sb_ff[10].octave == '0) ? acc_add : acc_ff + acc_add;
      recip   = fvn_pkg::RECIP_TBL[nm1_ff];
      sum_w   = (P_W'(hi_ff) <<< LO_W) + $signed(P_W'(lo_ff)) + RND;
      res_w   = sum_w >>> (fvn_pkg::MAX_OCTAVES + 38);
      if (res_w > SAT_HI) begin
         rsp_value_in = 16'sd32767;
      end else if (res_w < SAT_LO) begin
         rsp_value_in = -16'sd32768;
      end else begin
         rsp_value_in = res_w[15:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_done_ff <= 1'b0;
         nrm_vld_ff  <= 1'b0;
      end else begin
         acc_done_ff <= sb_ff[10].vld && sb_ff[10].last;
         nrm_vld_ff  <= acc_done_ff;
      end
      if (sb_ff[10].vld) begin
         acc_ff <= acc_in;
      end
      lo_ff <= (LO_W+RC_W)'(acc_ff[LO_W-1:0]) * (LO_W+RC_W)'(recip);
      hi_ff <= (HI_W+RC_W+1)'($signed(acc_ff[ACC_W-1:LO_W]))
               * (HI_W+RC_W+1)'($signed({1'b0, recip}));
   end

   // ---------------------------------------------------------------- checks
   always_comb begin
      for (int i = 0; i < 11; i++) begin
         sb_vld[i] = sb_ff[i].vld;
      end
   end

   a_idle_empty: assert property (@(posedge clock) disable iff (reset)
      !busy |-> (sb_vld == '0) && !acc_done_ff && !nrm_vld_ff)
      else $error("pipe not empty while idle");

   a_take_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("transaction taken without going busy");

   a_one_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(busy))
      else $error("result without a transaction in flight");

endmodule

// ===== tb/tb_fbm_value_noise_3d.sv =====
// ----------------------------------------------------------------------------
// tb_fbm_value_noise_3d
// Drives sample points into the fractal value noise block through its
// start/busy port and checks every noise value against an in-bench model.
// ----------------------------------------------------------------------------
module tb_fbm_value_noise_3d;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int WATCHDOG_CYCLES = 2000;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_coord_x;
   logic signed [31:0] req_coord_y;
   logic signed [31:0] req_coord_z;
   logic [31:0]        req_noise_seed;
   logic [3:0]         req_octave_count;
   logic               rsp_valid;
   logic signed [15:0] rsp_noise_value;

   logic signed [15:0] noise_due[$];
   int                 n_errors;
   int                 idle_cycles;
   bit                 timed_out;

   fbm_value_noise_3d i_dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_coord_x      (req_coord_x),
      .req_coord_y      (req_coord_y),
      .req_coord_z      (req_coord_z),
      .req_noise_seed   (req_noise_seed),
      .req_octave_count (req_octave_count),
      .rsp_valid        (rsp_valid),
      .rsp_noise_value  (rsp_noise_value)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic logic [31:0] scramble(input logic [31:0] v);
      logic [31:0] x;
      x = v ^ (v >> 16);
      x = x * fvn_pkg::MIX_MUL_A;
      x = x ^ (x >> 15);
      x = x * fvn_pkg::MIX_MUL_B;
      x = x ^ (x >> 16);
      return x;
   endfunction

   function automatic longint corner_level(input logic [31:0] ix, input logic [31:0] iy,
                                           input logic [31:0] iz, input logic [31:0] seed);
      logic [31:0] h;
      h = seed * fvn_pkg::SEED_MUL;
      h = scramble(h ^ (ix * fvn_pkg::AXIS_MUL[0]));
      h = scramble(h ^ (iy * fvn_pkg::AXIS_MUL[1]));
      h = scramble(h ^ (iz * fvn_pkg::AXIS_MUL[2]));
      return longint'({32'd0, h}) - 64'sd2147483648;
   endfunction

   function automatic longint smoother(input logic [15:0] frac);
      longint t, t2, t3, p;
      t  = longint'({48'd0, frac});
      t2 = (t * t) >>> 16;
      t3 = (t2 * t) >>> 16;
      p  = (6 * t * t + (longint'(10) <<< 32) - 15 * (t <<< 16)) >>> 16;
      return (t3 * p) >>> 16;
   endfunction

   function automatic longint blend(input longint a, input longint b, input longint w);
      return a + ((b - a) * w >>> 16);
   endfunction

   function automatic logic signed [15:0] fbm_noise(input logic [31:0] px, input logic [31:0] py,
                                                    input logic [31:0] pz, input logic [31:0] seed,
                                                    input logic [3:0] count);
      logic [63:0] cx, cy, cz;
      logic [31:0] ix, iy, iz, s;
      longint      wx, wy, wz, x00, x10, x01, x11, y0, y1, acc, recip, res, den;
      int          n;
      acc = 0;
      n = (count < 1) ? 1 :
          (count > fvn_pkg::MAX_OCTAVES) ? fvn_pkg::MAX_OCTAVES : int'(count);
      for (int k = 0; k < n; k++) begin
         cx = {{32{px[31]}}, px} << k;
         cy = {{32{py[31]}}, py} << k;
         cz = {{32{pz[31]}}, pz} << k;
         ix = cx[fvn_pkg::FRAC_BITS +: 32];
         iy = cy[fvn_pkg::FRAC_BITS +: 32];
         iz = cz[fvn_pkg::FRAC_BITS +: 32];
         wx = smoother(cx[15:0]);
         wy = smoother(cy[15:0]);
         wz = smoother(cz[15:0]);
         s  = seed + k * fvn_pkg::SEED_STEP;
         x00 = blend(corner_level(ix, iy, iz, s), corner_level(ix + 1, iy, iz, s), wx);
         x10 = blend(corner_level(ix, iy + 1, iz, s),
                     corner_level(ix + 1, iy + 1, iz, s), wx);
         x01 = blend(corner_level(ix, iy, iz + 1, s),
                     corner_level(ix + 1, iy, iz + 1, s), wx);
         x11 = blend(corner_level(ix, iy + 1, iz + 1, s),
                     corner_level(ix + 1, iy + 1, iz + 1, s), wx);
         y0 = blend(x00, x10, wy);
         y1 = blend(x01, x11, wy);
         acc += blend(y0, y1, wz) * (longint'(1) <<< (fvn_pkg::MAX_OCTAVES - 1 - k));
      end
      den   = (longint'(1) <<< n) - 1;
      recip = ((longint'(1) <<< (22 + n)) + den / 2) / den;
      res   = (acc * recip + (longint'(1) <<< (fvn_pkg::MAX_OCTAVES + 37)))
              >>> (fvn_pkg::MAX_OCTAVES + 38);
      if (res > 32767) res = 32767;
      if (res < -32768) res = -32768;
      return res[15:0];
   endfunction

   task automatic send_point(input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
                             input logic [31:0] seed, input logic [3:0] count);
      int gap;
      gap = $urandom_range(0, 8);
      if (gap != 0) begin
         start <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      start            <= 1'b1;
      req_coord_x      <= px;
      req_coord_y      <= py;
      req_coord_z      <= pz;
      req_noise_seed   <= seed;
      req_octave_count <= count;
      do @(posedge clock); while (busy);
      noise_due = {noise_due, fbm_noise(px, py, pz, seed, count)};
      @(negedge clock);
   endtask

   task automatic drain;
      start <= 1'b0;
      while (noise_due.size() != 0) @(negedge clock);
      repeat (30) @(negedge clock);
   endtask

   task automatic test_octave_counts;
      for (int c = 0; c < 16; c++)
         send_point($urandom, $urandom, $urandom, $urandom, c[3:0]);
   endtask

   task automatic test_field_extremes;
      send_point(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h0, 4'd15);
      send_point(32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'hffff_ffff, 4'd8);
      send_point(32'h0, 32'h0, 32'h0, 32'h0, 4'd0);
      send_point(32'hffff_ffff, 32'h0000_ffff, 32'hffff_0000, 32'h1234_5678, 4'd3);
      send_point(32'h0000_8000, 32'hffff_8000, 32'h7fff_0000, 32'h8000_0000, 4'd8);
      drain();
   endtask

   task automatic test_random_points;
      logic [31:0] px, py, pz;
      for (int i = 0; i < 1330; i++) begin
         px = $urandom;
         py = $urandom;
         pz = $urandom;
         if ($urandom_range(0, 3) == 0) begin
            px = $signed(px) >>> $urandom_range(0, 24);
            py = $signed(py) >>> $urandom_range(0, 24);
            pz = $signed(pz) >>> $urandom_range(0, 24);
         end
         send_point(px, py, pz, $urandom, 4'($urandom_range(0, 15)));
         if (i == 600) drain();
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (noise_due.size() == 0) begin
            $display("%0t: unexpected noise value %0d", $time, rsp_noise_value);
            n_errors++;
         end else begin
            if (rsp_noise_value !== noise_due[0]) begin
               $display("%0t: noise_value expected %0d actual %0d",
                        $time, noise_due[0], rsp_noise_value);
               n_errors++;
            end
            void'(noise_due.pop_front());
         end
      end
   end

   always @(posedge clock) begin
      if (reset || rsp_valid || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > WATCHDOG_CYCLES && !timed_out) begin
         timed_out = 1'b1;
         $display("fbm_value_noise_3d test failed");
         $finish;
      end
   end

   initial begin
      n_errors         = 0;
      idle_cycles      = 0;
      timed_out        = 1'b0;
      reset            = 1'b1;
      start            = 1'b0;
      req_coord_x      = '0;
      req_coord_y      = '0;
      req_coord_z      = '0;
      req_noise_seed   = '0;
      req_octave_count = '0;
      repeat (8) @(negedge clock);
      reset <= 1'b0;
      test_field_extremes();
      test_octave_counts();
      test_random_points();
      drain();
      if (n_errors == 0 && noise_due.size() == 0) begin
         $display("fbm_value_noise_3d test passed");
      end else begin
         $display("fbm_value_noise_3d test failed");
      end
      $finish;
   end

endmodule
